FILE: rtl/utf8_to_unicode_escape_assert.svh
// Assertion macros for the utf8_to_unicode_escape RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef UTF8_TO_UNICODE_ESCAPE_ASSERT_SVH
`define UTF8_TO_UNICODE_ESCAPE_ASSERT_SVH

// Same-cycle implication.
`define U2UE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U2UE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/u2ue_pkg.sv
// Package for the UTF-8 to escape-text converter: constants, types and helpers.
// No dependencies; used by the controller, datapath and top level.
package u2ue_pkg;

  localparam int ACCUM_BITS_DEF = 24;
  localparam int CONT_BITS      = 6;
  localparam int ESC_MIN_DIGITS = 4;
  localparam int LEAD_BITS      = 5;

  localparam logic [6:0] CHAR_BSLASH = 7'h5c;
  localparam logic [6:0] CHAR_U      = 7'h75;
  localparam logic [6:0] CHAR_ZERO   = 7'h30;
  localparam logic [6:0] CHAR_A_OFS  = 7'h57;  // 'a' - 10

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_BS,
    S_U_CHAR,
    S_HEX
  } state_t;

  typedef enum logic [1:0] {
    K_BSLASH,
    K_U_CHAR,
    K_HEX
  } char_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       start_a;
    logic       start_b;
    logic       emit;
    char_kind_t kind;
    logic       last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic a_vld;
    logic b_vld;
    logic dig_zero;
    logic out_free;
  } stat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + n7;
    end else begin
      hex_char = CHAR_A_OFS + n7;
    end
  endfunction

  // Payload bits of a lead byte: skip the top two ones, up to four more
  // ones and one separator bit.
  function automatic logic [LEAD_BITS-1:0] lead_payload(input logic [7:0] b);
    if (!b[5]) begin
      lead_payload = b[4:0];
    end else if (!b[4]) begin
      lead_payload = {1'b0, b[3:0]};
    end else if (!b[3]) begin
      lead_payload = {2'b00, b[2:0]};
    end else if (!b[2]) begin
      lead_payload = {3'b000, b[1:0]};
    end else begin
      lead_payload = {4'b0000, b[0]};
    end
  endfunction

endpackage

FILE: rtl/u2ue_if.sv
// Handshake channel interfaces for the UTF-8 to escape-text converter.
// Depends on nothing; one interface per channel direction.
interface u2ue_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u2ue_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

FILE: rtl/utf8_to_unicode_escape.sv
// UTF-8 to escape-text converter. Raw UTF-8 bytes arrive one per transfer on
// in_ch, the last byte of a string marked by final_byte. Each decoded code
// point leaves on out_ch as ASCII text, one character per transfer: a
// backslash, a 'u', then at least four lowercase hex digits (more when the
// value needs them). run_last marks the last character caused by a byte; a
// continuation or lead byte that only updates the pending value causes no
// character at all. Decoding is lenient: nothing is validated, a stray
// continuation byte shifts its six bits into a value of zero and the
// accumulator keeps its low ACCUM_BITS bits. After a byte is accepted, each
// escape it causes is planned and then sent one character at a time (six to
// eight characters at ACCUM_BITS of 24); a byte that flushes a pending value
// besides its own escape causes two escapes. The single character output
// register sets the pace; a stalled sink holds the sequencer, and a new byte
// is taken as soon as the last character of the previous one sits in the
// output register.
// Depends on u2ue_pkg, u2ue_if, u2ue_ctrl and u2ue_dp.
module utf8_to_unicode_escape
  import u2ue_pkg::*;
#(
  parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  u2ue_in_if.sink    in_ch,
  u2ue_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accept, plan, then step through backslash, 'u' and digits.
  u2ue_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Accumulator, queued escapes and the output register.
  u2ue_dp #(
    .ACCUM_BITS (ACCUM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_char   (out_ch.out_char),
    .run_last   (out_ch.run_last)
  );

endmodule

FILE: rtl/u2ue_ctrl.sv
// Sequencing state machine: accept a byte, walk the escapes it causes.
// Depends on u2ue_pkg and utf8_to_unicode_escape_assert.svh.
`include "utf8_to_unicode_escape_assert.svh"

module u2ue_ctrl
  import u2ue_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.start_a = 1'b0;
    cmd.start_b = 1'b0;
    cmd.emit    = 1'b0;
    cmd.kind    = K_BSLASH;
    cmd.last    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        if (stat.a_vld) begin
          cmd.start_a = 1'b1;
          state_nxt   = S_BS;
        end else if (stat.b_vld) begin
          cmd.start_b = 1'b1;
          state_nxt   = S_BS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BS: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = K_BSLASH;
          state_nxt = S_U_CHAR;
        end
      end
      S_U_CHAR: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = K_U_CHAR;
          state_nxt = S_HEX;
        end
      end
      S_HEX: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = K_HEX;
          if (stat.dig_zero) begin
            cmd.last  = !stat.b_vld;
            state_nxt = stat.b_vld ? S_PLAN : S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `U2UE_ASSERT_NOW(a_last_nothing_left, cmd.emit && cmd.last, !stat.a_vld && !stat.b_vld, "last character flagged while an escape is still queued")
  `U2UE_ASSERT_NOW(a_load_when_drained, cmd.load, !stat.a_vld && !stat.b_vld, "byte accepted while escapes of the previous byte remain")
  `U2UE_ASSERT_NEXT(a_start_to_bslash, cmd.start_a || cmd.start_b, state_r == S_BS, "escape started without moving to the backslash step")
  `U2UE_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.load, cmd.start_a, cmd.start_b, cmd.emit}), "conflicting controller commands")

endmodule

FILE: rtl/u2ue_dp.sv
// Datapath: pending accumulator, queued escape values, digit counter, output register.
// Depends on u2ue_pkg; driven by u2ue_ctrl through cmd_t and reporting stat_t.
module u2ue_dp
  import u2ue_pkg::*;
#(
  parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [6:0]            out_char,
  output logic                  run_last
);

  localparam int NIB   = (ACCUM_BITS + 3) / 4;
  localparam int DIG_W = $clog2(NIB);
  localparam int HEX_W = NIB * 4;

  logic [ACCUM_BITS-1:0] pend_val_r, pend_val_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [ACCUM_BITS-1:0] esc_a_r, esc_b_r, esc_b_nxt;
  logic                  esc_a_vld_r, esc_b_vld_r, esc_b_vld_nxt;
  logic [HEX_W-1:0]      cur_r;
  logic [DIG_W-1:0]      dig_r;
  logic                  out_vld_r;
  logic [6:0]            out_char_r;
  logic                  run_last_r;

  logic                  is_ascii, is_lead;
  logic [ACCUM_BITS-1:0] upd_val;
  logic [ACCUM_BITS-1:0] start_val;
  logic [HEX_W-1:0]      start_hex;
  logic [DIG_W-1:0]      start_dig;
  logic [6:0]            char_sel;

  assign is_ascii = !data_byte[7];
  assign is_lead  = data_byte[7] && data_byte[6];

  // Value that a lead or continuation byte leaves pending.
  always_comb begin
    if (is_lead) begin
      upd_val = ACCUM_BITS'(lead_payload(data_byte));
    end else begin
      upd_val = {pend_val_r[ACCUM_BITS-CONT_BITS-1:0], data_byte[CONT_BITS-1:0]};
    end
  end

  always_comb begin
    if (is_ascii) begin
      esc_b_nxt     = ACCUM_BITS'(data_byte[6:0]);
      esc_b_vld_nxt = 1'b1;
      pend_val_nxt  = '0;
      pend_vld_nxt  = 1'b0;
    end else if (final_byte) begin
      esc_b_nxt     = upd_val;
      esc_b_vld_nxt = 1'b1;
      pend_val_nxt  = '0;
      pend_vld_nxt  = 1'b0;
    end else begin
      esc_b_nxt     = upd_val;
      esc_b_vld_nxt = 1'b0;
      pend_val_nxt  = upd_val;
      pend_vld_nxt  = 1'b1;
    end
  end

  // Leading digit: the top non-zero nibble, never below the fourth.
  assign start_val = cmd.start_a ? esc_a_r : esc_b_r;
  assign start_hex = HEX_W'(start_val);

  always_comb begin
    start_dig = DIG_W'(ESC_MIN_DIGITS - 1);
    for (int i = ESC_MIN_DIGITS; i < NIB; i++) begin
      if (start_hex[i*4 +: 4] != 4'h0) begin
        start_dig = DIG_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd.kind)
      K_BSLASH: char_sel = CHAR_BSLASH;
      K_U_CHAR: char_sel = CHAR_U;
      K_HEX:    char_sel = hex_char(cur_r[dig_r*4 +: 4]);
      default:  char_sel = CHAR_BSLASH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      pend_val_r  <= '0;
      esc_a_vld_r <= 1'b0;
      esc_b_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        esc_a_vld_r <= pend_vld_r && (is_ascii || is_lead);
        esc_b_vld_r <= esc_b_vld_nxt;
        pend_vld_r  <= pend_vld_nxt;
        pend_val_r  <= pend_val_nxt;
      end
      if (cmd.start_a) begin
        esc_a_vld_r <= 1'b0;
      end
      if (cmd.start_b) begin
        esc_b_vld_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      esc_a_r <= pend_val_r;
      esc_b_r <= esc_b_nxt;
    end
    if (cmd.start_a || cmd.start_b) begin
      cur_r <= start_hex;
      dig_r <= start_dig;
    end else if (cmd.emit && cmd.kind == K_HEX) begin
      dig_r <= dig_r - 1'b1;
    end
    if (cmd.emit) begin
      out_char_r <= char_sel;
      run_last_r <= cmd.last;
    end
  end

  assign stat.a_vld    = esc_a_vld_r;
  assign stat.b_vld    = esc_b_vld_r;
  assign stat.dig_zero = (dig_r == '0);
  assign stat.out_free = !out_vld_r || out_ready;

  assign out_valid = out_vld_r;
  assign out_char  = out_char_r;
  assign run_last  = run_last_r;

endmodule
